@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/mlfq_pkg.sv @@
// Types, codes and reset constants of the multilevel feedback queue scheduler.
// No dependencies.
package mlfq_pkg;

   localparam int DEF_QUEUE_DEPTH = 16;

   localparam logic [15:0] TOTAL_MEMORY_RESET = 16'd512;
   localparam logic [3:0]  TOTAL_TAPES_RESET  = 4'd4;
   localparam logic [7:0]  QUANTUM_ONE_RESET  = 8'd5;
   localparam logic [7:0]  QUANTUM_TWO_RESET  = 8'd10;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;

   localparam logic CMD_ADMIT = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   localparam logic [2:0] EV_IDLE        = 3'd0;
   localparam logic [2:0] EV_RAN         = 3'd1;
   localparam logic [2:0] EV_DEMOTED     = 3'd2;
   localparam logic [2:0] EV_TERMINATED  = 3'd3;
   localparam logic [2:0] EV_ADMIT_RUNS  = 3'd4;
   localparam logic [2:0] EV_ADMIT_WAITS = 3'd5;
   localparam logic [2:0] EV_REJECTED    = 3'd6;

   localparam logic [1:0] CSR_TOTAL_MEMORY = 2'd0;
   localparam logic [1:0] CSR_TOTAL_TAPES  = 2'd1;
   localparam logic [1:0] CSR_QUANTUM_ONE  = 2'd2;
   localparam logic [1:0] CSR_QUANTUM_TWO  = 2'd3;

   typedef struct packed {
      logic [15:0] time_left;
      logic [3:0]  tapes;
      logic [15:0] memory;
      logic [7:0]  job_id;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic push;
      logic pop;
      logic wr_front;
   } queue_ctl_type;

endpackage

@@ rtl/mlfq_ram.sv @@
// Generic single write port RAM with registered read.
// No dependencies.
module mlfq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/mlfq_queue.sv @@
// One level queue: head pointer, count, entry RAM and front bypass.
// Depends on mlfq_pkg and mlfq_ram.
module mlfq_queue import mlfq_pkg::*; #(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  queue_ctl_type                    ctl,
   input  entry_type                        push_data,
   input  entry_type                        upd_data,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0] count,
   output entry_type                        front
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = CW + 1;

   logic [AW-1:0]  head_ff, head_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           byp_ff, byp_in;
   entry_type      byp_data_ff;
   logic [SW-1:0]  tail_sum;
   logic [AW-1:0]  tail;
   logic           we;
   logic [AW-1:0]  waddr;
   entry_type      wdata;
   logic [ENTRY_W-1:0] rdata;

   always_comb begin
      tail_sum = SW'(head_ff) + SW'(count_ff);
      if (tail_sum >= SW'(QUEUE_DEPTH)) begin
         tail = AW'(tail_sum - SW'(QUEUE_DEPTH));
      end else begin
         tail = AW'(tail_sum);
      end
      we    = ctl.push | ctl.wr_front;
      waddr = ctl.push ? tail : head_ff;
      wdata = ctl.push ? push_data : upd_data;
      head_in = head_ff;
      if (ctl.pop) begin
         head_in = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + AW'(1);
      end
      count_in = count_ff + CW'(ctl.push) - CW'(ctl.pop);
      byp_in   = we && (waddr == head_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         byp_ff   <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         byp_ff   <= byp_in;
      end
      byp_data_ff <= wdata;
   end

   mlfq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (head_in),
      .rdata (rdata)
   );

   assign count = count_ff;
   assign front = byp_ff ? byp_data_ff : entry_type'(rdata);

endmodule

@@ rtl/multilevel_feedback_queue_scheduler_top.sv @@
// Top level of the three-level feedback queue scheduler.
// Depends on mlfq_pkg and mlfq_queue.
//
//   channel  direction  payload
//   req      in         tuser: cmd; tdata: job_id, memory_needed, tapes_needed, run_time
//   rsp      out        tuser: event_res; tdata: job_id_out, level, time_left,
//                       memory_free, tapes_free
//   csr      in         csr_index, csr_wdata; always ready
//
// One command per cycle unless rsp stalls; a req is held in the input register, then sets rsp_tvalid.
// The queue RAMs are read at the next head in the cycle before, with a bypass for
// a write to that entry, so the front entry is ready for the following command.
// Synchronous reset empties all queues and loads the register reset values.
// A stalled rsp holds its result; the input register takes one more item.
module multilevel_feedback_queue_scheduler_top import mlfq_pkg::*; #(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // job_id, memory_needed, tapes_needed, run_time
   input  logic [0:0]            req_tuser,  // cmd
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // job_id_out, level, time_left, memory_free,
                                             // tapes_free
   output logic [2:0]            rsp_tuser,  // event_res
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_wdata
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic        s1_valid_ff;
   logic        s1_cmd_ff;
   entry_type   s1_entry_ff;
   logic        advance;

   logic [15:0] total_memory_ff;
   logic [3:0]  total_tapes_ff;
   logic [7:0]  quantum_one_ff;
   logic [7:0]  quantum_two_ff;

   logic [CW-1:0] job_count_ff, job_count_in;
   logic [15:0]   mem_used_ff, mem_used_in;
   logic [3:0]    tapes_used_ff, tapes_used_in;
   logic [7:0]    qleft_one_ff, qleft_one_in;
   logic [7:0]    qleft_two_ff, qleft_two_in;

   queue_ctl_type q_ctl [3];
   logic [CW-1:0] q_count [3];
   entry_type     q_front [3];
   entry_type     push_entry;
   entry_type     upd_entry;

   logic          rsp_valid_ff;
   logic [2:0]    ev_ff, ev_in;
   logic [7:0]    id_ff, id_in;
   logic [1:0]    lvl_ff, lvl_in;
   logic [15:0]   tleft_ff, tleft_in;
   logic [15:0]   mem_free_ff, mem_free_in;
   logic [3:0]    tapes_free_ff, tapes_free_in;

   logic [1:0]    sel;
   logic          any_job;
   entry_type     cur;
   logic [7:0]    qcur;
   logic [7:0]    qreload;
   logic          over_mem;
   logic          over_tapes;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
      if (req_tready) begin
         s1_cmd_ff   <= req_tuser[0];
         s1_entry_ff <= entry_type'(req_tdata[ENTRY_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_memory_ff <= TOTAL_MEMORY_RESET;
         total_tapes_ff  <= TOTAL_TAPES_RESET;
         quantum_one_ff  <= QUANTUM_ONE_RESET;
         quantum_two_ff  <= QUANTUM_TWO_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TOTAL_MEMORY: total_memory_ff <= csr_wdata;
            CSR_TOTAL_TAPES:  total_tapes_ff  <= csr_wdata[3:0];
            CSR_QUANTUM_ONE:  quantum_one_ff  <= csr_wdata[7:0];
            CSR_QUANTUM_TWO:  quantum_two_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_level
      mlfq_queue #(
         .QUEUE_DEPTH (QUEUE_DEPTH)
      ) u_queue (
         .clock     (clock),
         .reset     (reset),
         .ctl       (q_ctl[g]),
         .push_data (push_entry),
         .upd_data  (upd_entry),
         .count     (q_count[g]),
         .front     (q_front[g])
      );
   end

   always_comb begin
      any_job = 1'b1;
      priority if (q_count[0] != '0) begin
         sel = 2'd0;
      end else if (q_count[1] != '0) begin
         sel = 2'd1;
      end else if (q_count[2] != '0) begin
         sel = 2'd2;
      end else begin
         sel     = 2'd0;
         any_job = 1'b0;
      end
      cur     = q_front[sel];
      qcur    = (sel == 2'd0) ? qleft_one_ff : qleft_two_ff;
      qreload = (sel == 2'd0) ? quantum_one_ff : quantum_two_ff;

      over_mem   = ({1'b0, mem_used_ff} + {1'b0, s1_entry_ff.memory})
                   > {1'b0, total_memory_ff};
      over_tapes = ({1'b0, tapes_used_ff} + {1'b0, s1_entry_ff.tapes})
                   > {1'b0, total_tapes_ff};

      upd_entry           = cur;
      upd_entry.time_left = cur.time_left - 16'd1;
      push_entry          = cur;

      for (int i = 0; i < 3; i++) begin
         q_ctl[i] = '0;
      end
      job_count_in  = job_count_ff;
      mem_used_in   = mem_used_ff;
      tapes_used_in = tapes_used_ff;
      qleft_one_in  = qleft_one_ff;
      qleft_two_in  = qleft_two_ff;
      ev_in         = EV_IDLE;
      id_in         = '0;
      lvl_in        = '0;
      tleft_in      = '0;

      if (advance) begin
         if (s1_cmd_ff == CMD_ADMIT) begin
            id_in    = s1_entry_ff.job_id;
            tleft_in = s1_entry_ff.time_left;
            if (over_mem || over_tapes || (job_count_ff >= CW'(QUEUE_DEPTH))) begin
               ev_in = EV_REJECTED;
            end else begin
               push_entry       = s1_entry_ff;
               q_ctl[0].push    = 1'b1;
               job_count_in     = job_count_ff + CW'(1);
               mem_used_in      = mem_used_ff + s1_entry_ff.memory;
               tapes_used_in    = tapes_used_ff + s1_entry_ff.tapes;
               ev_in            = (q_count[0] == '0) ? EV_ADMIT_RUNS : EV_ADMIT_WAITS;
               lvl_in           = 2'd1;
            end
         end else if (any_job) begin
            id_in = cur.job_id;
            if (cur.time_left == '0) begin
               q_ctl[sel].pop = 1'b1;
               mem_used_in    = mem_used_ff - cur.memory;
               tapes_used_in  = tapes_used_ff - cur.tapes;
               job_count_in   = job_count_ff - CW'(1);
               if (sel == 2'd0) begin
                  qleft_one_in = qreload;
               end else if (sel == 2'd1) begin
                  qleft_two_in = qreload;
               end
               ev_in  = EV_TERMINATED;
               lvl_in = sel + 2'd1;
            end else if ((sel == 2'd2) || (qcur != '0)) begin
               q_ctl[sel].wr_front = 1'b1;
               if (sel == 2'd0) begin
                  qleft_one_in = qleft_one_ff - 8'd1;
               end else if (sel == 2'd1) begin
                  qleft_two_in = qleft_two_ff - 8'd1;
               end
               ev_in    = EV_RAN;
               lvl_in   = sel + 2'd1;
               tleft_in = upd_entry.time_left;
            end else begin
               q_ctl[sel].pop = 1'b1;
               if (sel == 2'd0) begin
                  q_ctl[1].push = 1'b1;
                  qleft_one_in  = qreload;
               end else begin
                  q_ctl[2].push = 1'b1;
                  qleft_two_in  = qreload;
               end
               ev_in    = EV_DEMOTED;
               lvl_in   = sel + 2'd2;
               tleft_in = cur.time_left;
            end
         end
      end

      mem_free_in   = (mem_used_in > total_memory_ff) ? '0 : total_memory_ff - mem_used_in;
      tapes_free_in = (tapes_used_in > total_tapes_ff) ? '0 : total_tapes_ff - tapes_used_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_count_ff  <= '0;
         mem_used_ff   <= '0;
         tapes_used_ff <= '0;
         qleft_one_ff  <= QUANTUM_ONE_RESET;
         qleft_two_ff  <= QUANTUM_TWO_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         job_count_ff  <= job_count_in;
         mem_used_ff   <= mem_used_in;
         tapes_used_ff <= tapes_used_in;
         qleft_one_ff  <= qleft_one_in;
         qleft_two_ff  <= qleft_two_in;
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         ev_ff         <= ev_in;
         id_ff         <= id_in;
         lvl_ff        <= lvl_in;
         tleft_ff      <= tleft_in;
         mem_free_ff   <= mem_free_in;
         tapes_free_ff <= tapes_free_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = ev_ff;
   assign rsp_tdata  = {2'b00, tapes_free_ff, mem_free_ff, tleft_ff, lvl_ff, id_ff};

endmodule

@@ rtl/mlfq_checker.sv @@
// Port-level checks on the scheduler top level, bound to it below.
// Depends on mlfq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mlfq_checker import mlfq_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [2:0]            rsp_tuser
);

   `ASSERT_NEXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_tvalid)

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   `ASSERT_SAME(a_idle_empty, clock, reset, rsp_tvalid && (rsp_tuser == EV_IDLE),
      rsp_tdata[25:0] == '0)

   `ASSERT_SAME(a_terminated_done, clock, reset,
      rsp_tvalid && (rsp_tuser == EV_TERMINATED),
      (rsp_tdata[25:10] == '0) && (rsp_tdata[9:8] != 2'd0))

   `ASSERT_SAME(a_admit_level, clock, reset,
      rsp_tvalid && ((rsp_tuser == EV_ADMIT_RUNS) || (rsp_tuser == EV_ADMIT_WAITS)),
      rsp_tdata[9:8] == 2'd1)

endmodule

bind multilevel_feedback_queue_scheduler_top mlfq_checker u_checker (.*);
